/* rtl/cpack_word_codec_assert.svh */
// assertion macros used by the codec top level
`ifndef CPACK_WORD_CODEC_ASSERT_SVH
`define CPACK_WORD_CODEC_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define CPWC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cpwc check failed");

// next-cycle implication, sampled on clk, off during reset
`define CPWC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cpwc check failed");

`endif

/* rtl/cpwc_pkg.sv */
// types and constants of the c-pack word codec
package cpwc_pkg;

  localparam int DICT_ENTRIES_DEF = 16;
  localparam int IDX_W            = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 36;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LEN  = 2'd2;

  // register reset values
  localparam logic [23:0] CODE_TABLE_RST = 24'hDCE210;
  localparam logic [35:0] LEN_TABLE_RST  = {6'd12, 6'd24, 6'd16, 6'd6, 6'd34, 6'd2};

  typedef enum logic [2:0] {
    PAT_ZZZZ = 3'd0,
    PAT_XXXX = 3'd1,
    PAT_MMMM = 3'd2,
    PAT_MMMX = 3'd3,
    PAT_MMXX = 3'd4,
    PAT_ZZZX = 3'd5
  } pat_t;

  // best dictionary match found so far
  typedef enum logic [1:0] {
    LVL_NONE  = 2'd0,
    LVL_HALF  = 2'd1,
    LVL_THREE = 2'd2,
    LVL_FULL  = 2'd3
  } lvl_t;

  typedef struct packed {
    logic        line_start;
    logic [31:0] plain_word;
    logic [35:0] packed_in;
  } in_item_t;

  typedef struct packed {
    logic [35:0] packed_out;
    logic [5:0]  packed_bits;
    logic [9:0]  line_bits;
    logic [31:0] plain_out;
    logic [2:0]  pattern;
  } out_item_t;

  // word in flight along the cell row
  typedef struct packed {
    logic             vld;
    logic             dec;
    logic             search;
    pat_t             pat;
    logic [IDX_W-1:0] idx;
    logic [31:0]      word;
    lvl_t             lvl;
    logic [IDX_W-1:0] pos;
    logic [31:0]      rd;
  } probe_t;

endpackage

/* rtl/cpwc_cell.sv */
// one dictionary cell: holds an entry and checks the passing word against it
module cpwc_cell
  import cpwc_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        clear,
  input  logic        wr_en,
  input  logic [31:0] wr_data,
  input  logic        hold,
  input  probe_t      probe_in,
  output probe_t      probe_out
);

  localparam logic [IDX_W-1:0] CELL_ID = IDX_W'(IDX);

  logic        valid_r;
  logic [31:0] word_r;
  probe_t      probe_r;
  probe_t      probe_nxt;
  logic        valid_eff;
  logic [31:0] word_eff;

  // a line start in this cycle empties the entry before the compare
  assign valid_eff = valid_r & ~clear;
  assign word_eff  = clear ? '0 : word_r;

  // compare against the entry, or pick it up for a decode
  always_comb begin
    probe_nxt = probe_in;
    if (probe_in.vld) begin
      if (!probe_in.dec && probe_in.search && valid_eff) begin
        if (word_eff == probe_in.word && probe_in.lvl != LVL_FULL) begin
          probe_nxt.lvl = LVL_FULL;
          probe_nxt.pos = CELL_ID;
        end else if (probe_in.lvl != LVL_FULL && probe_in.lvl != LVL_THREE &&
                     word_eff[31:8] == probe_in.word[31:8]) begin
          probe_nxt.lvl = LVL_THREE;
          probe_nxt.pos = CELL_ID;
        end else if (probe_in.lvl == LVL_NONE &&
                     word_eff[31:16] == probe_in.word[31:16]) begin
          probe_nxt.lvl = LVL_HALF;
          probe_nxt.pos = CELL_ID;
        end
      end
      if (probe_in.dec && probe_in.idx == CELL_ID) begin
        probe_nxt.rd = word_eff;
      end
    end
  end

  // dictionary entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      word_r  <= '0;
    end else if (clear) begin
      valid_r <= 1'b0;
      word_r  <= '0;
    end else if (wr_en) begin
      valid_r <= 1'b1;
      word_r  <= wr_data;
    end
  end

  // hand the word on to the next cell
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      probe_r.vld <= 1'b0;
    end else if (!hold) begin
      probe_r <= probe_nxt;
    end
  end

  assign probe_out = probe_r;

endmodule

/* rtl/cpack_word_codec.sv */
// c-pack word codec top level: entry decode, cell row, result and output register
// a word walks through the cell registers in turn; its result then goes to the output register
// a new word is taken only once the previous one has left the cell row
// a waiting result does not block the next word from entering the row
// reset (synchronous, rst_n low) empties the dictionary, zeroes the bit total
// and loads the register defaults; no clearing pass is needed
module cpack_word_codec
  import cpwc_pkg::*;
#(
  parameter int DICT_ENTRIES = DICT_ENTRIES_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "cpack_word_codec_assert.svh"

  localparam int CNT_W = $clog2(DICT_ENTRIES + 1);

  logic        mode_r;
  logic [23:0] code_table_r;
  logic [35:0] len_table_r;

  logic             busy_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic [9:0]       bit_total_r;
  logic [9:0]       bit_total_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic        in_accept;
  logic        clear;
  probe_t      entry;
  probe_t      chain [DICT_ENTRIES];
  probe_t      lp;
  logic [DICT_ENTRIES-1:0] cell_vld;

  logic        fire;
  logic        last_hold;
  logic        append;
  logic [31:0] app_word;
  pat_t        pat;
  logic [3:0]  code;
  logic [5:0]  len;
  logic [35:0] packed_val;
  logic [31:0] plain_val;
  logic [10:0] sum;
  logic [9:0]  total_val;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= 1'b0;
      code_table_r <= CODE_TABLE_RST;
      len_table_r  <= LEN_TABLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE: mode_r       <= cfg_wdata[0];
        CFG_CODE: code_table_r <= cfg_wdata[23:0];
        CFG_LEN:  len_table_r  <= cfg_wdata;
        default:  ;
      endcase
    end
  end

  assign in_stall  = busy_r;
  assign in_accept = in_valid & ~in_stall;
  assign clear     = in_accept & in_data.line_start;

  // classify the incoming word before it enters the row
  always_comb begin
    entry        = '0;
    entry.vld    = in_accept;
    entry.dec    = mode_r;
    entry.lvl    = LVL_NONE;
    entry.pat    = PAT_ZZZZ;
    if (!mode_r) begin
      entry.word   = in_data.plain_word;
      entry.search = |in_data.plain_word[31:8];
      if (|in_data.plain_word[31:8]) begin
        entry.pat = PAT_XXXX;
      end else if (|in_data.plain_word[7:0]) begin
        entry.pat = PAT_ZZZX;
      end
    end else begin
      entry.word = in_data.packed_in[31:0];
      if (in_data.packed_in[32]) begin
        entry.pat = PAT_XXXX;
      end else if (|in_data.packed_in[23:20]) begin
        entry.pat = PAT_MMXX;
        entry.idx = in_data.packed_in[19:16];
      end else if (|in_data.packed_in[15:12]) begin
        entry.pat = PAT_MMMX;
        entry.idx = in_data.packed_in[11:8];
      end else if (|in_data.packed_in[11:8]) begin
        entry.pat = PAT_ZZZX;
      end else if (|in_data.packed_in[7:4]) begin
        entry.pat = PAT_MMMM;
        entry.idx = in_data.packed_in[3:0];
      end
    end
  end

  // row of dictionary cells
  for (genvar k = 0; k < DICT_ENTRIES; k++) begin : g_cell
    probe_t cell_in;
    logic   cell_wr;
    logic   cell_hold;

    if (k == 0) begin : g_head
      assign cell_in = entry;
    end else begin : g_link
      assign cell_in = chain[k-1];
    end

    assign cell_wr     = append && (count_r == CNT_W'(k));
    assign cell_hold   = (k == DICT_ENTRIES - 1) ? last_hold : 1'b0;
    assign cell_vld[k] = chain[k].vld;

    cpwc_cell #(
      .IDX (k)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .clear     (clear),
      .wr_en     (cell_wr),
      .wr_data   (app_word),
      .hold      (cell_hold),
      .probe_in  (cell_in),
      .probe_out (chain[k])
    );
  end

  assign lp        = chain[DICT_ENTRIES-1];
  assign last_hold = lp.vld & out_valid_r & out_stall;
  assign fire      = lp.vld & ~(out_valid_r & out_stall);

  // final pattern
  always_comb begin
    pat = lp.pat;
    if (!lp.dec && lp.search) begin
      case (lp.lvl)
        LVL_FULL:  pat = PAT_MMMM;
        LVL_THREE: pat = PAT_MMMX;
        LVL_HALF:  pat = PAT_MMXX;
        default:   pat = PAT_XXXX;
      endcase
    end
  end

  // table lookups
  always_comb begin
    case (pat)
      PAT_ZZZZ: begin code = code_table_r[3:0];   len = len_table_r[5:0];   end
      PAT_XXXX: begin code = code_table_r[7:4];   len = len_table_r[11:6];  end
      PAT_MMMM: begin code = code_table_r[11:8];  len = len_table_r[17:12]; end
      PAT_MMMX: begin code = code_table_r[15:12]; len = len_table_r[23:18]; end
      PAT_MMXX: begin code = code_table_r[19:16]; len = len_table_r[29:24]; end
      PAT_ZZZX: begin code = code_table_r[23:20]; len = len_table_r[35:30]; end
      default:  begin code = '0;                  len = '0;                 end
    endcase
  end

  // packed code word in compress mode, rebuilt word in decompress mode
  always_comb begin
    packed_val = '0;
    plain_val  = '0;
    if (!lp.dec) begin
      case (pat)
        PAT_ZZZZ: packed_val = {32'd0, code};
        PAT_ZZZX: packed_val = {24'd0, code, lp.word[7:0]};
        PAT_MMMM: packed_val = {28'd0, code, lp.pos};
        PAT_MMMX: packed_val = {20'd0, code, lp.pos, lp.word[7:0]};
        PAT_MMXX: packed_val = {12'd0, code, lp.pos, lp.word[15:0]};
        PAT_XXXX: packed_val = {code, lp.word};
        default:  packed_val = '0;
      endcase
    end else begin
      case (pat)
        PAT_XXXX: plain_val = lp.word;
        PAT_MMXX: plain_val = {lp.rd[31:16], lp.word[15:0]};
        PAT_MMMX: plain_val = {lp.rd[31:8], lp.word[7:0]};
        PAT_ZZZX: plain_val = {24'd0, lp.word[7:0]};
        PAT_MMMM: plain_val = lp.rd;
        default:  plain_val = '0;
      endcase
    end
  end

  // append while the dictionary has room
  always_comb begin
    append = 1'b0;
    if (fire && count_r < CNT_W'(DICT_ENTRIES)) begin
      if (!lp.dec) begin
        append = lp.search;
      end else begin
        append = pat inside {PAT_XXXX, PAT_MMXX, PAT_MMMX, PAT_MMMM};
      end
    end
  end

  // word stored in the dictionary: the plain word, or the rebuilt one when decoding
  assign app_word = lp.dec ? plain_val : lp.word;

  // saturating bit total
  assign sum       = {1'b0, bit_total_r} + {5'd0, len};
  assign total_val = sum[10] ? 10'h3FF : sum[9:0];

  always_comb begin
    count_nxt     = count_r;
    bit_total_nxt = bit_total_r;
    if (clear) begin
      count_nxt     = '0;
      bit_total_nxt = '0;
    end else if (fire) begin
      bit_total_nxt = total_val;
      if (append) begin
        count_nxt = count_r + 1'b1;
      end
    end
  end

  // line state and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      count_r     <= '0;
      bit_total_r <= '0;
    end else begin
      count_r     <= count_nxt;
      bit_total_r <= bit_total_nxt;
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (fire) begin
        busy_r <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r.packed_out  <= packed_val;
      out_data_r.packed_bits <= len;
      out_data_r.line_bits   <= total_val;
      out_data_r.plain_out   <= plain_val;
      out_data_r.pattern     <= pat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  `CPWC_ASSERT_NEXT(a_one_word_at_a_time, in_valid && !in_stall, in_stall)
  `CPWC_ASSERT_NOW(a_single_word_in_row, 1'b1, $onehot0(cell_vld))
  `CPWC_ASSERT_NEXT(a_append_counts, append, count_r == $past(count_r) + 1'b1)
  `CPWC_ASSERT_NEXT(a_total_grows, fire, bit_total_r >= $past(bit_total_r))

endmodule

/* tb/testbench.sv */
// self-checking testbench for the c-pack word codec: random and directed words, both modes
module testbench;
  import cpwc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  // settling time after the last result, covers the walk along the cell row
  localparam int SETTLE = 2 * DICT_ENTRIES_DEF + 8;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  in_item_t              in_data = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  // words waiting to be sent and code results still owed by the block
  in_item_t  words_to_send[$];
  out_item_t code_results_due[$];
  int        mismatches = 0;
  int        cycles = 0;
  int        send_gap = 0;
  int        stall_left = 0;
  bit        calm = 1'b0;
  out_item_t got;
  out_item_t want;

  // mirror of the codec state and registers
  logic [31:0] dict_mem[16];
  int          dict_fill = 0;
  int          line_total = 0;
  bit          cur_mode = 1'b0;
  logic [23:0] code_tab = CODE_TABLE_RST;
  logic [35:0] len_tab = LEN_TABLE_RST;

  // stimulus history of the current line, used to build matching words
  logic [31:0] line_history[$];
  int          gen_fill = 0;

  cpack_word_codec dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #4 clk = ~clk;

  // encode or decode one word and advance the dictionary and line total
  function automatic out_item_t cpack_code(in_item_t it);
    out_item_t   r;
    pat_t        pat;
    logic [31:0] w;
    logic [31:0] base;
    logic [35:0] c;
    logic [3:0]  code;
    logic [3:0]  pos;
    int          best;
    int          total;
    r = '0;
    best = 0;
    pos = '0;
    if (it.line_start) begin
      foreach (dict_mem[i]) dict_mem[i] = '0;
      dict_fill = 0;
      line_total = 0;
    end
    if (!cur_mode) begin
      w = it.plain_word;
      if (w[31:8] == 24'd0) begin
        pat = (w[7:0] != 8'd0) ? PAT_ZZZX : PAT_ZZZZ;
      end else begin
        // first full match wins, otherwise the first of the best partial level
        for (int i = 0; i < dict_fill; i++) begin
          if (dict_mem[i] == w) begin
            pos = 4'(i);
            best = 4;
            break;
          end
          if (best < 3 && dict_mem[i][31:8] == w[31:8]) begin
            pos = 4'(i);
            best = 3;
          end else if (best < 2 && dict_mem[i][31:16] == w[31:16]) begin
            pos = 4'(i);
            best = 2;
          end
        end
        if (dict_fill < 16) begin
          dict_mem[dict_fill] = w;
          dict_fill++;
        end
        pat = (best == 4) ? PAT_MMMM : (best == 3) ? PAT_MMMX :
              (best == 2) ? PAT_MMXX : PAT_XXXX;
      end
      code = code_tab[4*int'(pat) +: 4];
      case (pat)
        PAT_ZZZZ: r.packed_out = 36'(code);
        PAT_ZZZX: r.packed_out = 36'({code, w[7:0]});
        PAT_MMMM: r.packed_out = 36'({code, pos});
        PAT_MMMX: r.packed_out = 36'({code, pos, w[7:0]});
        PAT_MMXX: r.packed_out = 36'({code, pos, w[15:0]});
        default:  r.packed_out = {code, w};
      endcase
    end else begin
      // nibble flags decide the layout, highest flag first
      c = it.packed_in;
      if (c[32]) begin
        pat = PAT_XXXX;
        r.plain_out = c[31:0];
      end else if (c[23:20] != 4'd0) begin
        pat = PAT_MMXX;
        base = dict_mem[c[19:16]];
        r.plain_out = {base[31:16], c[15:0]};
      end else if (c[15:12] != 4'd0) begin
        pat = PAT_MMMX;
        base = dict_mem[c[11:8]];
        r.plain_out = {base[31:8], c[7:0]};
      end else if (c[11:8] != 4'd0) begin
        pat = PAT_ZZZX;
        r.plain_out = {24'd0, c[7:0]};
      end else if (c[7:4] != 4'd0) begin
        pat = PAT_MMMM;
        r.plain_out = dict_mem[c[3:0]];
      end else begin
        pat = PAT_ZZZZ;
      end
      if (pat != PAT_ZZZZ && pat != PAT_ZZZX && dict_fill < 16) begin
        dict_mem[dict_fill] = r.plain_out;
        dict_fill++;
      end
    end
    r.packed_bits = len_tab[6*int'(pat) +: 6];
    total = line_total + int'(r.packed_bits);
    if (total > 1023) total = 1023;
    line_total = total;
    r.line_bits = 10'(total);
    r.pattern = pat;
    return r;
  endfunction

  function automatic void compare_field(string fld, logic [35:0] exp_v, logic [35:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h got %h", $time, fld, exp_v, act_v);
      mismatches++;
    end
  endfunction

  // random word, mostly shaped to hit dictionary matches or valid packed layouts
  function automatic in_item_t random_word_item(bit m);
    in_item_t    it;
    logic [31:0] h;
    logic [3:0]  idx;
    int          kind;
    it.line_start = ($urandom_range(0, 23) == 0);
    it.plain_word = $urandom;
    it.packed_in = {4'($urandom_range(0, 15)), 32'($urandom)};
    kind = $urandom_range(0, 99);
    if (it.line_start) begin
      line_history.delete();
      gen_fill = 0;
    end
    if (!m) begin
      h = (line_history.size() > 0) ?
          line_history[$urandom_range(0, line_history.size() - 1)] : 32'($urandom);
      if (kind < 8) it.plain_word = '0;
      else if (kind < 16) it.plain_word = 32'($urandom_range(1, 255));
      else if (kind < 36) it.plain_word = h;
      else if (kind < 52) it.plain_word = {h[31:8], 8'($urandom)};
      else if (kind < 66) it.plain_word = {h[31:16], 16'($urandom)};
      if (it.plain_word[31:8] != 24'd0) begin
        line_history.push_back(it.plain_word);
        if (line_history.size() > 32) void'(line_history.pop_front());
      end
    end else begin
      idx = (gen_fill == 0 || $urandom_range(0, 9) == 0) ?
            4'($urandom_range(0, 15)) : 4'($urandom_range(0, gen_fill - 1));
      if (kind < 94) it.packed_in[32] = 1'b0;
      if (kind < 20) begin
        it.packed_in[32] = 1'b1;
      end else if (kind < 40) begin
        it.packed_in[23:20] = 4'($urandom_range(1, 15));
        it.packed_in[19:16] = idx;
      end else if (kind < 94) begin
        it.packed_in[23:20] = 4'd0;
        if (kind < 58) begin
          it.packed_in[15:12] = 4'($urandom_range(1, 15));
          it.packed_in[11:8] = idx;
        end else begin
          it.packed_in[15:12] = 4'd0;
          if (kind < 68) begin
            it.packed_in[11:8] = 4'($urandom_range(1, 15));
          end else begin
            it.packed_in[11:8] = 4'd0;
            if (kind < 86) begin
              it.packed_in[7:4] = 4'($urandom_range(1, 15));
              it.packed_in[3:0] = idx;
            end else begin
              it.packed_in[7:4] = 4'd0;
            end
          end
        end
      end
      if ((kind < 58 || (kind >= 68 && kind < 86)) && gen_fill < 16) gen_fill++;
    end
    return it;
  endfunction

  task automatic queue_word(bit ls, logic [31:0] pw, logic [35:0] pk);
    in_item_t it;
    it.line_start = ls;
    it.plain_word = pw;
    it.packed_in = pk;
    words_to_send.push_back(it);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MODE: cur_mode = val[0];
      CFG_CODE: code_tab = val[23:0];
      CFG_LEN:  len_tab = val;
      default:  ;
    endcase
  endtask

  // hold off until every word has gone through and every result has come back
  task automatic wait_quiet();
    do @(posedge clk);
    while (words_to_send.size() != 0 || in_valid || code_results_due.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic run_phase(bit m, logic [23:0] ct, logic [35:0] lt, int n, bit quiet);
    wait_quiet();
    calm = quiet;
    write_reg(CFG_MODE, 36'(m));
    write_reg(CFG_CODE, 36'(ct));
    write_reg(CFG_LEN, lt);
    line_history.delete();
    gen_fill = 0;
    repeat (n) words_to_send.push_back(random_word_item(m));
  endtask

  // input driver: records each accepted word, then offers the next or idles
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) code_results_due.push_back(cpack_code(in_data));
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (words_to_send.size() == 0) begin
          in_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
          send_gap = $urandom_range(0, 7);
          in_valid <= 1'b0;
        end else begin
          in_data <= words_to_send.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // result monitor with random stall bursts
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (code_results_due.size() == 0) begin
          $display("%0t: unexpected word, expected none got %p", $time, got);
          mismatches++;
        end else begin
          want = code_results_due.pop_front();
          compare_field("packed_out", want.packed_out, got.packed_out);
          compare_field("packed_bits", 36'(want.packed_bits), 36'(got.packed_bits));
          compare_field("line_bits", 36'(want.line_bits), 36'(got.line_bits));
          compare_field("plain_out", 36'(want.plain_out), 36'(got.plain_out));
          compare_field("pattern", 36'(want.pattern), 36'(got.pattern));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // compress: zero, low byte, literal, full, three-byte and two-byte matches
    queue_word(1'b1, 32'h0000_0000, 36'hF_FFFF_FFFF);
    queue_word(1'b0, 32'h0000_00FF, 36'h0_0000_0000);
    queue_word(1'b0, 32'h0000_0001, 36'hA_5A5A_5A5A);
    queue_word(1'b0, 32'hFFFF_FFFF, 36'h5_A5A5_A5A5);
    queue_word(1'b0, 32'hFFFF_FFFF, 36'h0_0000_0000);
    queue_word(1'b0, 32'hFFFF_FF00, 36'h0_0000_0000);
    queue_word(1'b0, 32'hFFFF_1234, 36'h0_0000_0000);
    queue_word(1'b0, 32'h8000_0000, 36'h0_0000_0000);
    queue_word(1'b0, 32'h8000_0100, 36'h0_0000_0000);
    queue_word(1'b0, 32'h0000_0100, 36'h0_0000_0000);
    queue_word(1'b0, 32'h7FFF_FFFF, 36'h0_0000_0000);
    queue_word(1'b0, 32'h7FFF_FFFF, 36'h0_0000_0000);
    queue_word(1'b0, 32'h0000_ABCD, 36'h0_0000_0000);
    queue_word(1'b1, 32'hFFFF_FFFF, 36'h0_0000_0000);

    // decompress: every layout, ignored top bits, unwritten and cleared entries
    wait_quiet();
    write_reg(CFG_MODE, 36'd1);
    queue_word(1'b1, 32'hFFFF_FFFF, 36'h1_1234_5678);
    queue_word(1'b0, 32'h0000_0000, 36'hE_ABCD_5678);
    queue_word(1'b0, 32'h0000_0000, 36'h0_00D0_9ABC);
    queue_word(1'b0, 32'h0000_0000, 36'h0_0000_3001);
    queue_word(1'b0, 32'h0000_0000, 36'h0_0000_0A7F);
    queue_word(1'b0, 32'h0000_0000, 36'h0_0000_0021);
    queue_word(1'b0, 32'h0000_0000, 36'h0_FF0F_000F);
    queue_word(1'b0, 32'h0000_0000, 36'hF_FFFF_FFFF);
    queue_word(1'b0, 32'h0000_0000, 36'h0_0000_0000);
    queue_word(1'b0, 32'h0000_0000, 36'h0_0000_00F0);
    queue_word(1'b1, 32'h0000_0000, 36'h0_0000_004F);

    // random phases across register settings, extremes included
    run_phase(1'b0, CODE_TABLE_RST, LEN_TABLE_RST, 300, 1'b0);
    run_phase(1'b1, CODE_TABLE_RST, LEN_TABLE_RST, 250, 1'b0);
    run_phase(1'b0, 24'hFF_FFFF, 36'hF_FFFF_FFFF, 150, 1'b0);
    run_phase(1'b1, 24'h00_0000, 36'h0_0000_0000, 100, 1'b0);
    run_phase(1'b0, 24'($urandom), {4'($urandom), 32'($urandom)}, 150, 1'b0);
    run_phase(1'b1, 24'($urandom), {4'($urandom), 32'($urandom)}, 100, 1'b0);
    run_phase(1'b0, 24'($urandom), {4'($urandom), 32'($urandom)}, 100, 1'b1);
    wait_quiet();

    if (mismatches == 0 && code_results_due.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
